// File: src/fsth_pkg.sv
`timescale 1ns / 1ps

package fsth_pkg;

   // action codes carried in req_tuser
   typedef enum logic [1:0] {
      ACT_TICK       = 2'd0,
      ACT_DECIDE     = 2'd1,
      ACT_CLEAR_AGE  = 2'd2,
      ACT_CLEAR_HOURS = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      REASON_DISARMED = 3'd0,
      REASON_BLIND    = 3'd1,
      REASON_HOLD     = 3'd2,
      REASON_COLD     = 3'd3,
      REASON_WARM     = 3'd4
   } reason_type;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_HEAT_DAYS_LIMIT   = 2'd0,
      CSR_ROOM_TARGET_DECI  = 2'd1,
      CSR_MIN_CYCLE_SECONDS = 2'd2,
      CSR_UNUSED            = 2'd3
   } csr_index_type;

   localparam int TEMP_W        = 11;
   localparam int DAYS_W        = 8;
   localparam int SECONDS_W     = 16;
   localparam int HOURS_W       = 16;
   localparam int LIMIT_W       = 13;  // 255 days * 24
   localparam int MIN_MS_W      = 26;  // 65535 s * 1000
   localparam int HOURS_PER_DAY = 24;
   localparam int MS_PER_S      = 1000;
   localparam int HYST_DECI     = 3;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 56;

   // rsp_tdata field positions
   localparam int RSP_REQ_BIT     = 0;
   localparam int RSP_REASON_LSB  = 1;
   localparam int RSP_PERSIST_BIT = 4;
   localparam int RSP_WDOG_LSB    = 5;
   localparam int RSP_HOURS_LSB   = 37;

   localparam logic [DAYS_W-1:0]    DAYS_RESET   = 8'd7;
   localparam logic [TEMP_W-1:0]    TARGET_RESET = 11'd200;
   localparam logic [SECONDS_W-1:0] SECONDS_RESET = 16'd300;

   typedef struct packed {
      action_type         action;
      logic [31:0]        elapsed_ms;
      logic               remote_owns_mode;
      logic               reading_ok;
      logic signed [TEMP_W-1:0] room_deci;
      logic               sent_heat_bit;
   } item_type;

endpackage

// File: src/failsafe_thermostat_heat_arm.sv
`timescale 1ns / 1ps

// Failsafe heat arm: hour accounting and bang-bang verdict for a boiler link.
// Input stream req_*: one item per transfer; req_tuser carries the action
// (tick, decide, clear heat bit age, clear heat hours). Result stream rsp_*:
// exactly one result per item, in order, carrying the verdict, the persist
// strobe, the watchdog and the heat-hours count after the item.
// Config port csr_*: writes register csr_index with csr_wdata; always ready.
// Path: each item passes the four divider stages for elapsed_ms / HOUR_MS,
// then the state update into the result register.
// Throughput: one item per cycle while the result is not stalled by
// rsp_tready; the state update reads the state registers directly, so
// back-to-back ticks and decisions are taken without gaps.
// Reset clears all state and loads the registers with 7 days, 20.0 degrees
// and 300 s. When rsp_tready is low the result register holds and the
// pipeline keeps accepting items until its stages are full, then req_tready
// drops.
module failsafe_thermostat_heat_arm import fsth_pkg::*; #(
   parameter int unsigned HOUR_MS = 3600000
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // elapsed_ms[31:0], remote_owns_mode[32], reading_ok[33], room_deci[44:34],
   // sent_heat_bit[45], zero fill
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // action[1:0]
   input  logic [1:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // heat_request[0], verdict_reason[3:1], persist_now[4], watchdog_ms[36:5],
   // heat_hours_count[52:37], zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [SECONDS_W-1:0]  csr_wdata
);

   localparam int FRAC_W = $clog2(HOUR_MS);
   localparam int QUOT_W = $clog2(64'hFFFF_FFFF / HOUR_MS + 1);
   localparam longint unsigned Q_SAT = 64'hFFFF_FFFF / HOUR_MS;
   localparam longint unsigned R_SAT = 64'hFFFF_FFFF % HOUR_MS;
   localparam int SUM_W = ((QUOT_W > HOURS_W) ? QUOT_W : HOURS_W) + 1;
   localparam int CMP_W = TEMP_W + 2;

   item_type            req_item;
   item_type            div_item;
   logic                div_valid;
   logic                div_ready;
   logic [QUOT_W-1:0]   div_quot;
   logic [FRAC_W-1:0]   div_rem;
   logic                step;

   // configuration
   logic signed [TEMP_W-1:0] target_ff;
   logic [LIMIT_W-1:0]       limit_hours_ff;
   logic [MIN_MS_W-1:0]      min_ms_ff;

   // state
   logic [31:0]         wdog_ff, wdog_in;
   logic [31:0]         age_ff, age_in;
   logic [FRAC_W-1:0]   frac_ff, frac_in;
   logic [HOURS_W-1:0]  hours_ff, hours_in;
   logic                want_ff, want_in;

   // result
   logic                rsp_valid_ff;
   logic                heat_req_ff, heat_req_in;
   reason_type          reason_ff, reason_in;
   logic                persist_ff, persist_in;

   logic [32:0]         wdog_sum, age_sum, frac_sum;
   logic [FRAC_W:0]     rem_sum;
   logic                rem_wrap;
   logic [QUOT_W-1:0]   new_hours;
   logic [SUM_W-1:0]    hours_sum;
   logic signed [CMP_W-1:0] room_x, cold_edge, warm_edge;
   logic                disarmed, want_tmp;

   assign req_item.action           = action_type'(req_tuser);
   assign req_item.elapsed_ms       = req_tdata[31:0];
   assign req_item.remote_owns_mode = req_tdata[32];
   assign req_item.reading_ok       = req_tdata[33];
   assign req_item.room_deci        = req_tdata[44:34];
   assign req_item.sent_heat_bit    = req_tdata[45];

   fsth_div #(
      .HOUR_MS (HOUR_MS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (req_item),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_item  (div_item),
      .out_quot  (div_quot),
      .out_rem   (div_rem)
   );

   assign div_ready = !rsp_valid_ff || rsp_tready;
   assign step      = div_valid && div_ready;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff      <= TARGET_RESET;
         limit_hours_ff <= LIMIT_W'(DAYS_RESET) * LIMIT_W'(HOURS_PER_DAY);
         min_ms_ff      <= MIN_MS_W'(SECONDS_RESET) * MIN_MS_W'(MS_PER_S);
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_HEAT_DAYS_LIMIT: begin
               limit_hours_ff <= LIMIT_W'(csr_wdata[DAYS_W-1:0]) * LIMIT_W'(HOURS_PER_DAY);
            end
            CSR_ROOM_TARGET_DECI: begin
               target_ff <= csr_wdata[TEMP_W-1:0];
            end
            CSR_MIN_CYCLE_SECONDS: begin
               min_ms_ff <= MIN_MS_W'(csr_wdata) * MIN_MS_W'(MS_PER_S);
            end
            default: begin
            end
         endcase
      end
   end

   // tick arithmetic: the hour accumulator saturates before whole hours come out
   assign wdog_sum = {1'b0, wdog_ff} + {1'b0, div_item.elapsed_ms};
   assign age_sum  = {1'b0, age_ff} + {1'b0, div_item.elapsed_ms};
   assign frac_sum = 33'(frac_ff) + {1'b0, div_item.elapsed_ms};
   assign rem_sum  = (FRAC_W+1)'(frac_ff) + (FRAC_W+1)'(div_rem);
   assign rem_wrap = rem_sum >= (FRAC_W+1)'(HOUR_MS);

   always_comb begin
      if (frac_sum[32]) begin
         new_hours = QUOT_W'(Q_SAT);
      end else begin
         new_hours = div_quot + QUOT_W'(rem_wrap);
      end
   end

   assign hours_sum = SUM_W'(hours_ff) + SUM_W'(new_hours);

   // hysteresis edges, both inclusive
   assign room_x    = CMP_W'(div_item.room_deci);
   assign cold_edge = CMP_W'(target_ff) - CMP_W'(HYST_DECI);
   assign warm_edge = CMP_W'(target_ff) + CMP_W'(HYST_DECI);
   assign disarmed  = hours_ff >= HOURS_W'(limit_hours_ff);

   always_comb begin
      wdog_in     = wdog_ff;
      age_in      = age_ff;
      frac_in     = frac_ff;
      hours_in    = hours_ff;
      want_in     = want_ff;
      heat_req_in = 1'b0;
      reason_in   = REASON_DISARMED;
      persist_in  = 1'b0;
      want_tmp    = want_ff;
      unique case (div_item.action)
         ACT_TICK: begin
            if (!div_item.remote_owns_mode) begin
               wdog_in = '0;
            end else if (wdog_sum[32]) begin
               wdog_in = '1;
            end else begin
               wdog_in = wdog_sum[31:0];
            end
            age_in = age_sum[32] ? '1 : age_sum[31:0];
            if (frac_sum[32]) begin
               frac_in = FRAC_W'(R_SAT);
            end else if (rem_wrap) begin
               frac_in = FRAC_W'(rem_sum - (FRAC_W+1)'(HOUR_MS));
            end else begin
               frac_in = rem_sum[FRAC_W-1:0];
            end
            if (new_hours != '0) begin
               persist_in = hours_ff < HOURS_W'(limit_hours_ff);
               hours_in   = (hours_sum > SUM_W'({HOURS_W{1'b1}})) ? '1
                                                                  : hours_sum[HOURS_W-1:0];
            end
         end
         ACT_DECIDE: begin
            priority if (disarmed) begin
               want_in = 1'b0;
            end else if (!div_item.reading_ok) begin
               want_in     = 1'b1;
               heat_req_in = 1'b1;
               reason_in   = REASON_BLIND;
            end else begin
               if (room_x <= cold_edge) begin
                  want_tmp = 1'b1;
               end else if (room_x >= warm_edge) begin
                  want_tmp = 1'b0;
               end
               want_in = want_tmp;
               // minimum on/off time counted on the bit actually sent
               if (want_tmp != div_item.sent_heat_bit && age_ff < 32'(min_ms_ff)) begin
                  heat_req_in = div_item.sent_heat_bit;
                  reason_in   = REASON_HOLD;
               end else begin
                  heat_req_in = want_tmp;
                  reason_in   = want_tmp ? REASON_COLD : REASON_WARM;
               end
            end
         end
         ACT_CLEAR_AGE: begin
            age_in = '0;
         end
         ACT_CLEAR_HOURS: begin
            hours_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wdog_ff      <= '0;
         age_ff       <= '0;
         frac_ff      <= '0;
         hours_ff     <= '0;
         want_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (div_ready) rsp_valid_ff <= div_valid;
         if (step) begin
            wdog_ff  <= wdog_in;
            age_ff   <= age_in;
            frac_ff  <= frac_in;
            hours_ff <= hours_in;
            want_ff  <= want_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         heat_req_ff <= heat_req_in;
         reason_ff   <= reason_in;
         persist_ff  <= persist_in;
      end
   end

   // watchdog and hours are the state registers, updated with the result
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, hours_ff, wdog_ff, persist_ff, reason_ff, heat_req_ff};

endmodule

// File: src/fsth_div.sv
`timescale 1ns / 1ps

// divides elapsed_ms by the hour length through a reciprocal multiply,
// carrying the rest of the item alongside
module fsth_div import fsth_pkg::*; #(
   parameter int unsigned HOUR_MS = 3600000
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   output logic     out_valid,
   input  logic     out_ready,
   output item_type out_item,
   output logic [$clog2(64'hFFFF_FFFF / HOUR_MS + 1)-1:0] out_quot,
   output logic [$clog2(HOUR_MS)-1:0] out_rem
);

   localparam int FRAC_W = $clog2(HOUR_MS);
   localparam longint unsigned RECIP = 64'h1_0000_0000 / HOUR_MS;
   localparam int RECIP_W = $clog2(RECIP + 1);
   localparam int QUOT_W = $clog2(64'hFFFF_FFFF / HOUR_MS + 1);
   localparam int PROD_W = 32 + RECIP_W;

   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic s1_ready, s2_ready, s3_ready, s4_ready;

   item_type s1_item_ff, s2_item_ff, s3_item_ff, s4_item_ff;
   logic [QUOT_W-1:0] s2_quot_ff, s3_quot_ff, s4_quot_ff;
   logic [FRAC_W:0]   s3_rem_ff;
   logic [FRAC_W-1:0] s4_rem_ff;

   logic [PROD_W-1:0] prod_in;
   logic [31:0]       qd;
   logic [31:0]       rem_raw;
   logic [QUOT_W-1:0] quot_in;
   logic [FRAC_W-1:0] rem_in;

   assign s4_ready = !s4_valid_ff || out_ready;
   assign s3_ready = !s3_valid_ff || s4_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   // estimate is the true quotient or one below it
   assign prod_in = PROD_W'(s1_item_ff.elapsed_ms) * PROD_W'(RECIP);
   assign qd      = 32'(s2_quot_ff) * 32'(HOUR_MS);
   assign rem_raw = s2_item_ff.elapsed_ms - qd;

   always_comb begin
      if (s3_rem_ff >= (FRAC_W+1)'(HOUR_MS)) begin
         quot_in = s3_quot_ff + QUOT_W'(1);
         rem_in  = FRAC_W'(s3_rem_ff - (FRAC_W+1)'(HOUR_MS));
      end else begin
         quot_in = s3_quot_ff;
         rem_in  = s3_rem_ff[FRAC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= in_valid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
         if (s3_ready) s3_valid_ff <= s2_valid_ff;
         if (s4_ready) s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && in_valid) begin
         s1_item_ff <= in_item;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_item_ff <= s1_item_ff;
         s2_quot_ff <= prod_in[32 +: QUOT_W];
      end
      if (s3_ready && s2_valid_ff) begin
         s3_item_ff <= s2_item_ff;
         s3_quot_ff <= s2_quot_ff;
         s3_rem_ff  <= rem_raw[FRAC_W:0];
      end
      if (s4_ready && s3_valid_ff) begin
         s4_item_ff <= s3_item_ff;
         s4_quot_ff <= quot_in;
         s4_rem_ff  <= rem_in;
      end
   end

   assign out_valid = s4_valid_ff;
   assign out_item  = s4_item_ff;
   assign out_quot  = s4_quot_ff;
   assign out_rem   = s4_rem_ff;

endmodule

// File: src/fsth_checker.sv
`timescale 1ns / 1ps

module fsth_checker import fsth_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic       rsp_req;
   logic [2:0] rsp_reason;
   logic       rsp_persist;

   assign rsp_req     = rsp_tdata[RSP_REQ_BIT];
   assign rsp_reason  = rsp_tdata[RSP_REASON_LSB +: 3];
   assign rsp_persist = rsp_tdata[RSP_PERSIST_BIT];

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp payload changed while stalled");

   // no result is valid right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid right after reset");

   // persist strobe only on ticks, which carry no verdict
   a_persist_tick: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_persist |-> !rsp_req && rsp_reason == REASON_DISARMED)
      else $error("persist strobe with a verdict");

   // reasons that imply the request bit
   a_reason_req: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_reason == REASON_COLD || rsp_reason == REASON_BLIND) |-> rsp_req)
      else $error("heating reason without request");

   a_reason_noreq: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_reason == REASON_WARM || rsp_reason == REASON_DISARMED) |-> !rsp_req)
      else $error("request with a no-heat reason");

endmodule

bind failsafe_thermostat_heat_arm fsth_checker u_fsth_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// File: sim/failsafe_thermostat_heat_arm_tb.sv
`timescale 1ns / 1ps

module failsafe_thermostat_heat_arm_tb;
   import fsth_pkg::*;

   localparam int unsigned HOUR_MS     = 3600000;
   localparam int          CYCLE_LIMIT = 400000;
   localparam int          DRAIN_WAIT  = 12;

   typedef struct {
      logic        heat_request;
      logic [2:0]  reason;
      logic        persist;
      logic [31:0] watchdog;
      logic [15:0] hours;
   } heat_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [1:0]            req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [1:0]            csr_index = '0;
   logic [SECONDS_W-1:0]  csr_wdata = '0;

   failsafe_thermostat_heat_arm #(.HOUR_MS(HOUR_MS)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   // shadow copy of the controller: registers and state
   logic [7:0]         cfg_days = DAYS_RESET;
   logic signed [10:0] cfg_target = TARGET_RESET;
   logic [15:0]        cfg_min_s = SECONDS_RESET;
   logic [31:0]        wdog_ms = '0;
   logic [31:0]        bit_age_ms = '0;
   logic [31:0]        hour_frac_ms = '0;
   logic [15:0]        powered_hours = '0;
   logic               want_heat = 1'b0;

   item_type        item_queue[$];
   heat_result_type expected_results[$];
   item_type        cur_item;
   bit              holding = 1'b0;
   int              req_gap = 0;
   bit              req_steady = 1'b0;
   int              rsp_stall = 0;
   bit              rsp_steady = 1'b0;
   bit              hold_request = 1'b0;
   int              hold_left = 0;
   int              error_count = 0;
   int              cycle_count = 0;

   function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   function automatic heat_result_type heat_arm_step(item_type it);
      heat_result_type r;
      logic [31:0]  acc;
      int unsigned  whole;
      int unsigned  hsum;
      int           limit;
      int           room;
      int           target;
      r.heat_request = 1'b0;
      r.reason = REASON_DISARMED;
      r.persist = 1'b0;
      limit = int'(cfg_days) * HOURS_PER_DAY;
      room = int'(it.room_deci);
      target = int'(cfg_target);
      case (it.action)
         ACT_TICK: begin
            wdog_ms = it.remote_owns_mode ? sat_add(wdog_ms, it.elapsed_ms) : '0;
            bit_age_ms = sat_add(bit_age_ms, it.elapsed_ms);
            acc = sat_add(hour_frac_ms, it.elapsed_ms);
            whole = acc / HOUR_MS;
            hour_frac_ms = acc % HOUR_MS;
            if (whole != 0) begin
               r.persist = (int'(powered_hours) < limit);
               hsum = powered_hours + whole;
               powered_hours = (hsum > 65535) ? 16'hFFFF : hsum[15:0];
            end
         end
         ACT_DECIDE: begin
            if (int'(powered_hours) >= limit) begin
               want_heat = 1'b0;
            end else if (!it.reading_ok) begin
               want_heat = 1'b1;
               r.heat_request = 1'b1;
               r.reason = REASON_BLIND;
            end else begin
               if (room <= target - HYST_DECI)
                  want_heat = 1'b1;
               else if (room >= target + HYST_DECI)
                  want_heat = 1'b0;
               // minimum on/off time is measured on the bit actually sent
               if (want_heat != it.sent_heat_bit &&
                   longint'(bit_age_ms) < longint'(cfg_min_s) * MS_PER_S) begin
                  r.heat_request = it.sent_heat_bit;
                  r.reason = REASON_HOLD;
               end else begin
                  r.heat_request = want_heat;
                  r.reason = want_heat ? REASON_COLD : REASON_WARM;
               end
            end
         end
         ACT_CLEAR_AGE: bit_age_ms = '0;
         default: powered_hours = '0;
      endcase
      r.watchdog = wdog_ms;
      r.hours = powered_hours;
      return r;
   endfunction

   function automatic item_type make_item(action_type act, logic [31:0] ms, bit remote,
                                          bit fresh, int room, bit sent);
      item_type it;
      it.action = act;
      it.elapsed_ms = ms;
      it.remote_owns_mode = remote;
      it.reading_ok = fresh;
      it.room_deci = 11'(room);
      it.sent_heat_bit = sent;
      return it;
   endfunction

   function automatic item_type random_item(int clear_hours_pct, int huge_pct);
      int          r;
      int          room;
      logic [31:0] ms;
      action_type  act;
      r = $urandom_range(0, 99);
      if (r < clear_hours_pct)
         act = ACT_CLEAR_HOURS;
      else if (r < clear_hours_pct + 8)
         act = ACT_CLEAR_AGE;
      else if (r < clear_hours_pct + 53)
         act = ACT_TICK;
      else
         act = ACT_DECIDE;
      r = $urandom_range(0, 99);
      if (r < 25)
         ms = $urandom_range(0, 2000);
      else if (r < 50)
         ms = $urandom_range(0, 400000);
      else if (r < 70)
         ms = $urandom_range(3000000, 8000000);
      else if (r < 70 + huge_pct)
         ms = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom;
      else
         ms = $urandom_range(0, 100000000);
      // most readings sit around the target so the hysteresis band is exercised
      if ($urandom_range(0, 9) < 7)
         room = int'(cfg_target) + $urandom_range(0, 12) - 6;
      else
         room = $urandom_range(0, 1400) - 400;
      if (room < -400)
         room = -400;
      if (room > 1000)
         room = 1000;
      return make_item(act, ms, $urandom_range(0, 1), $urandom_range(0, 3) != 0, room,
                       $urandom_range(0, 1));
   endfunction

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_results.push_back(heat_arm_step(cur_item));
            holding = 1'b0;
            if ($urandom_range(0, 99) < 3)
               req_steady = ~req_steady;
            req_gap = req_steady ? 0 : $urandom_range(0, 17);
         end
         if (!holding) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (item_queue.size() > 0) begin
               cur_item = item_queue.pop_front();
               holding = 1'b1;
            end
         end
         req_tvalid <= holding;
         req_tdata <= {2'b00, cur_item.sent_heat_bit, cur_item.room_deci,
                       cur_item.reading_ok, cur_item.remote_owns_mode, cur_item.elapsed_ms};
         req_tuser <= cur_item.action;
      end
   end

   task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
      if (exp_v != act_v) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
         error_count++;
      end
   endtask

   // long hold-off so the pipeline fills and backs up the input
   always @(posedge clock) begin
      if (hold_request) begin
         hold_left <= 300;
         hold_request = 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // receiver
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: result transfer with none expected, expected none, actual %h",
                        $time, rsp_tdata);
               error_count++;
            end else begin
               heat_result_type e;
               e = expected_results.pop_front();
               check_field("heat_request", e.heat_request, rsp_tdata[RSP_REQ_BIT]);
               check_field("verdict_reason", e.reason, rsp_tdata[RSP_REASON_LSB +: 3]);
               check_field("persist_now", e.persist, rsp_tdata[RSP_PERSIST_BIT]);
               check_field("watchdog_ms", e.watchdog, rsp_tdata[RSP_WDOG_LSB +: 32]);
               check_field("heat_hours_count", e.hours, rsp_tdata[RSP_HOURS_LSB +: 16]);
            end
            if ($urandom_range(0, 99) < 3)
               rsp_steady = ~rsp_steady;
            rsp_stall = rsp_steady ? 0 : $urandom_range(0, 17);
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= (hold_left == 0);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** failsafe_thermostat_heat_arm: FAILED **");
         $finish;
      end
   end

   task automatic write_csr(csr_index_type idx, logic [15:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_HEAT_DAYS_LIMIT:   cfg_days = value[7:0];
         CSR_ROOM_TARGET_DECI:  cfg_target = value[10:0];
         CSR_MIN_CYCLE_SECONDS: cfg_min_s = value;
         default: ;
      endcase
   endtask

   task automatic configure(int days, int target, int min_s);
      write_csr(CSR_HEAT_DAYS_LIMIT, 16'(days));
      write_csr(CSR_ROOM_TARGET_DECI, 16'(target));
      write_csr(CSR_MIN_CYCLE_SECONDS, 16'(min_s));
   endtask

   task automatic run_random(int count, int clear_hours_pct, int huge_pct);
      repeat (count) item_queue.push_back(random_item(clear_hours_pct, huge_pct));
   endtask

   task automatic wait_drained();
      while (item_queue.size() > 0 || holding || expected_results.size() > 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset settings: 7 days, target 200, 300 s
      item_queue.push_back(make_item(ACT_TICK, 0, 1, 1, 0, 0));
      item_queue.push_back(make_item(ACT_DECIDE, 0, 0, 1, 197, 0));
      item_queue.push_back(make_item(ACT_DECIDE, 0, 0, 1, 200, 0));
      item_queue.push_back(make_item(ACT_TICK, 300000, 1, 0, 0, 0));
      item_queue.push_back(make_item(ACT_DECIDE, 0, 0, 1, 197, 0));
      item_queue.push_back(make_item(ACT_DECIDE, 0, 1, 1, 203, 1));
      item_queue.push_back(make_item(ACT_TICK, 3599999, 1, 1, 0, 1));
      item_queue.push_back(make_item(ACT_TICK, 1, 1, 0, 0, 0));
      item_queue.push_back(make_item(ACT_DECIDE, 0, 0, 0, -400, 0));
      item_queue.push_back(make_item(ACT_CLEAR_AGE, 32'hFFFF_FFFF, 1, 1, 1000, 1));
      item_queue.push_back(make_item(ACT_DECIDE, 0, 0, 1, 1000, 1));
      item_queue.push_back(make_item(ACT_DECIDE, 0, 0, 1, -400, 0));
      // saturating watchdog and age, many hours at once, past the limit
      item_queue.push_back(make_item(ACT_TICK, 32'hFFFF_FFFF, 1, 0, 0, 0));
      item_queue.push_back(make_item(ACT_TICK, 32'hFFFF_FFFF, 1, 0, 0, 0));
      item_queue.push_back(make_item(ACT_DECIDE, 0, 0, 1, -400, 1));
      item_queue.push_back(make_item(ACT_TICK, 5, 0, 1, 0, 0));
      item_queue.push_back(make_item(ACT_CLEAR_HOURS, 32'hFFFF_FFFF, 1, 1, -1, 1));
      item_queue.push_back(make_item(ACT_DECIDE, 0, 0, 1, 196, 0));
      item_queue.push_back(make_item(ACT_DECIDE, 0, 0, 1, 204, 0));
      item_queue.push_back(make_item(ACT_CLEAR_AGE, 0, 0, 0, 0, 0));
      item_queue.push_back(make_item(ACT_DECIDE, 0, 0, 1, 201, 1));
      item_queue.push_back(make_item(ACT_DECIDE, 0, 0, 1, 203, 1));
      run_random(120, 5, 5);
      wait_drained();

      configure(0, -400, 0);
      run_random(100, 5, 5);
      wait_drained();

      configure(255, 1000, 65535);
      hold_request = 1'b1;
      run_random(150, 0, 30);
      wait_drained();

      configure(1, 0, 2);
      run_random(100, 8, 5);
      wait_drained();

      repeat (2) begin
         configure($urandom_range(0, 255), $urandom_range(0, 1400) - 400,
                   $urandom_range(0, 600));
         run_random(90, 5, 10);
         wait_drained();
      end

      if (error_count == 0)
         $display("** failsafe_thermostat_heat_arm: PASSED **");
      else
         $display("** failsafe_thermostat_heat_arm: FAILED **");
      $finish;
   end

endmodule

// File: failsafe_thermostat_heat_arm.f
src/fsth_pkg.sv
src/fsth_div.sv
src/failsafe_thermostat_heat_arm.sv
src/fsth_checker.sv
sim/failsafe_thermostat_heat_arm_tb.sv
